// ===== hdl/tlw_pkg.sv =====
// Shared types, constants and helpers for the text line-wrap layout block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tlw_pkg;

  // Glyph advance widths in pixels
  localparam int SINGLE_GLYPH_WIDTH = 8;
  localparam int DOUBLE_GLYPH_WIDTH = 16;

  localparam logic [11:0] COORD_MAX = 12'hFFF;

  // Character codes
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_HI   = 8'h7E;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;

  // Work queue between the classifier and the executor
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Stream widths
  localparam int TDATA_W   = 56;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_HEIGHT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ASCII_OFFSET_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_MIN       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TRAIL_MIN      = 3'd7;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_DOUBLE = 2'd1,
    KIND_END    = 2'd2
  } kind_t;

  typedef struct packed {
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [11:0] wrap_width;
    logic [11:0] bottom_limit;
    logic [6:0]  line_height;
    logic [5:0]  ascii_offset_y;
    logic [7:0]  lead_min;
    logic [7:0]  trail_min;
  } cfg_t;

  // What a held lead byte turns into
  typedef enum logic [1:0] {
    PAIR_NONE   = 2'd0,
    PAIR_SINGLE = 2'd1,
    PAIR_DOUBLE = 2'd2
  } pair_op_t;

  // What the current byte turns into
  typedef enum logic [1:0] {
    BYTE_NONE    = 2'd0,
    BYTE_NEWLINE = 2'd1,
    BYTE_SINGLE  = 2'd2
  } byte_op_t;

  typedef struct packed {
    pair_op_t    pair_op;
    logic [15:0] pair_code;
    byte_op_t    byte_op;
    logic [7:0]  byte_code;
    logic        fin;
  } entry_t;

  typedef struct packed {
    kind_t       kind;
    logic [11:0] glyph_x;
    logic [11:0] glyph_y;
    logic [15:0] glyph_code;
    logic [11:0] next_line_y;
    logic        run_end;
  } result_t;

  function automatic logic [11:0] sat12(input logic [12:0] v);
    return v[12] ? COORD_MAX : v[11:0];
  endfunction

  function automatic logic [7:0] print_code(input logic [7:0] b);
    return (b >= PRINT_LO && b <= PRINT_HI) ? b : CHAR_QMARK;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tlw_front.sv =====
// Byte classifier: pairs lead and trail bytes and turns each byte that needs work into a work entry.
// Depends on tlw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlw_front (
  input  logic           clk,
  input  logic           rst,
  input  tlw_pkg::cfg_t  cfg,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [7:0]     s_tdata,
  input  logic           s_tlast,
  input  logic           q_full,
  output logic           push,
  output tlw_pkg::entry_t entry
);

  logic       held_valid;
  logic [7:0] held_lead;
  logic       accept;
  logic       hold_new;
  logic       handle_byte;
  logic       is_nl;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && !q_full;
  assign is_nl    = (s_tdata == tlw_pkg::CHAR_CR) || (s_tdata == tlw_pkg::CHAR_LF);

  always_comb begin
    entry.pair_op   = tlw_pkg::PAIR_NONE;
    entry.pair_code = 16'h0000;
    entry.byte_op   = tlw_pkg::BYTE_NONE;
    entry.byte_code = 8'h00;
    entry.fin       = s_tlast;
    hold_new        = 1'b0;
    handle_byte     = 1'b1;

    if (held_valid) begin
      if (s_tdata >= cfg.trail_min) begin
        entry.pair_op   = tlw_pkg::PAIR_DOUBLE;
        entry.pair_code = {held_lead, s_tdata};
        handle_byte     = 1'b0;
      end else begin
        entry.pair_op   = tlw_pkg::PAIR_SINGLE;
        entry.pair_code = {8'h00, tlw_pkg::print_code(held_lead)};
      end
    end

    if (handle_byte) begin
      if (is_nl) begin
        entry.byte_op = tlw_pkg::BYTE_NEWLINE;
      end else if (s_tdata >= cfg.lead_min && !s_tlast) begin
        hold_new = 1'b1;
      end else begin
        entry.byte_op   = tlw_pkg::BYTE_SINGLE;
        entry.byte_code = tlw_pkg::print_code(s_tdata);
      end
    end
  end

  // A byte that is only held as a lead needs no work in the executor.
  assign push = accept && (entry.pair_op != tlw_pkg::PAIR_NONE ||
                           entry.byte_op != tlw_pkg::BYTE_NONE || entry.fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= hold_new;
    end
    if (accept) begin
      held_lead <= s_tdata;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tlw_queue.sv =====
// Short work queue between the byte classifier and the layout executor.
// Depends on tlw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tlw_pkg::entry_t wr_entry,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output tlw_pkg::entry_t head
);

  tlw_pkg::entry_t                 slots [tlw_pkg::QUEUE_DEPTH];
  logic [tlw_pkg::QPTR_W-1:0]      wr_ptr;
  logic [tlw_pkg::QPTR_W-1:0]      rd_ptr;
  logic [tlw_pkg::QPTR_W:0]        count;
  logic                            do_push;
  logic                            do_pop;

  assign full    = (count == (tlw_pkg::QPTR_W + 1)'(tlw_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tlw_back.sv =====
// Layout executor: runs each queued entry against the cursor, one step a cycle unless the
// result stream stalls, and drives that stream through a pending and an output register.
// Depends on tlw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlw_back (
  input  logic              clk,
  input  logic              rst,
  input  tlw_pkg::cfg_t     cfg,
  input  logic              q_empty,
  input  tlw_pkg::entry_t   head,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output tlw_pkg::result_t  m_res
);

  typedef enum logic [1:0] {
    STEP_PAIR = 2'd0,
    STEP_BYTE = 2'd1,
    STEP_END  = 2'd2
  } step_t;

  // Cursor; nl holds the exact row + line_height
  logic [11:0] col;
  logic [11:0] row;
  logic [12:0] nl;
  logic        halted;
  logic        fresh;
  logic        done_pair;
  logic        done_byte;

  logic             p_valid;
  tlw_pkg::result_t p_res;
  logic             o_valid;
  tlw_pkg::result_t o_res;

  logic [11:0] col_e;
  logic [11:0] row_e;
  logic [12:0] nl_e;
  step_t       cur;
  logic        last;
  logic        dbl;
  logic        newline_step;
  logic [15:0] code;
  logic [12:0] w13;
  logic        wrap;
  logic [11:0] row_sat_nl;
  logic [12:0] nl2;
  logic [11:0] r1;
  logic [11:0] col1;
  logic        below;
  logic [11:0] col_after;
  logic [11:0] gy_plain;
  logic [11:0] gy_wrap;
  logic [11:0] gy_single;
  logic        r_valid;
  tlw_pkg::result_t r_res;
  logic        o_free;
  logic        step;
  logic        p_move;

  assign col_e = fresh ? cfg.origin_x : col;
  assign row_e = fresh ? cfg.origin_y : row;
  assign nl_e  = fresh ? ({1'b0, cfg.origin_y} + {6'b0, cfg.line_height}) : nl;

  always_comb begin
    if (head.pair_op != tlw_pkg::PAIR_NONE && !done_pair) begin
      cur  = STEP_PAIR;
      last = (head.byte_op == tlw_pkg::BYTE_NONE) && !head.fin;
    end else if (head.byte_op != tlw_pkg::BYTE_NONE && !done_byte) begin
      cur  = STEP_BYTE;
      last = !head.fin;
    end else begin
      cur  = STEP_END;
      last = 1'b1;
    end
  end

  assign dbl          = (cur == STEP_PAIR) && (head.pair_op == tlw_pkg::PAIR_DOUBLE);
  assign newline_step = (cur == STEP_BYTE) && (head.byte_op == tlw_pkg::BYTE_NEWLINE);
  assign code         = (cur == STEP_PAIR) ? head.pair_code : {8'h00, head.byte_code};
  assign w13          = dbl ? 13'(tlw_pkg::DOUBLE_GLYPH_WIDTH)
                            : 13'(tlw_pkg::SINGLE_GLYPH_WIDTH);

  // Wrap only when the glyph is not the first on its line.
  assign wrap = (col_e != cfg.origin_x) &&
                (({1'b0, col_e} + w13) > ({1'b0, cfg.origin_x} + {1'b0, cfg.wrap_width}));

  assign row_sat_nl = tlw_pkg::sat12(nl_e);
  assign nl2        = {1'b0, row_sat_nl} + {6'b0, cfg.line_height};
  assign r1         = wrap ? row_sat_nl : row_e;
  assign col1       = wrap ? cfg.origin_x : col_e;
  assign below      = wrap ? (nl2 > {1'b0, cfg.bottom_limit})
                           : (nl_e > {1'b0, cfg.bottom_limit});
  assign col_after  = wrap ? tlw_pkg::sat12({1'b0, cfg.origin_x} + w13)
                           : tlw_pkg::sat12({1'b0, col_e} + w13);
  assign gy_plain   = tlw_pkg::sat12({1'b0, row_e} + {7'b0, cfg.ascii_offset_y});
  assign gy_wrap    = tlw_pkg::sat12({1'b0, row_sat_nl} + {7'b0, cfg.ascii_offset_y});
  assign gy_single  = wrap ? gy_wrap : gy_plain;

  always_comb begin
    r_res.kind        = tlw_pkg::KIND_END;
    r_res.glyph_x     = 12'h000;
    r_res.glyph_y     = 12'h000;
    r_res.glyph_code  = 16'h0000;
    r_res.next_line_y = 12'h000;
    r_res.run_end     = last;
    r_valid           = 1'b0;
    unique case (cur)
      STEP_END: begin
        r_valid           = 1'b1;
        r_res.next_line_y = (nl_e > {1'b0, cfg.bottom_limit}) ? cfg.bottom_limit : nl_e[11:0];
      end
      STEP_PAIR, STEP_BYTE: begin
        r_valid          = !newline_step && !halted && !below;
        r_res.kind       = dbl ? tlw_pkg::KIND_DOUBLE : tlw_pkg::KIND_SINGLE;
        r_res.glyph_x    = col1;
        r_res.glyph_y    = dbl ? r1 : gy_single;
        r_res.glyph_code = code;
      end
      default: begin
        r_valid = 1'b0;
      end
    endcase
  end

  // A pending result leaves either once its run_end is known, or when a later
  // result of the same byte pushes it out, which proves it was not the last.
  assign o_free = !o_valid || m_tready;
  assign step   = !q_empty && (!r_valid || !p_valid || o_free);
  assign p_move = p_valid && o_free && (p_res.run_end || (step && r_valid));
  assign pop    = step && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid   <= 1'b0;
      p_valid   <= 1'b0;
      done_pair <= 1'b0;
      done_byte <= 1'b0;
      fresh     <= 1'b1;
      halted    <= 1'b0;
    end else begin
      if (p_move) begin
        o_valid <= 1'b1;
        o_res   <= p_res;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end

      if (step && r_valid) begin
        p_valid <= 1'b1;
        p_res   <= r_res;
      end else if (p_move) begin
        p_valid <= 1'b0;
      end else if (step && last && p_valid) begin
        p_res.run_end <= 1'b1;
      end

      if (step) begin
        if (last) begin
          done_pair <= 1'b0;
          done_byte <= 1'b0;
        end else if (cur == STEP_PAIR) begin
          done_pair <= 1'b1;
        end else begin
          done_byte <= 1'b1;
        end

        fresh <= (cur == STEP_END);
        if (cur == STEP_END) begin
          halted <= 1'b0;
        end else if (!halted) begin
          if (newline_step) begin
            col    <= cfg.origin_x;
            row    <= row_sat_nl;
            nl     <= nl2;
            halted <= (nl2 > {1'b0, cfg.bottom_limit});
          end else begin
            row    <= r1;
            nl     <= wrap ? nl2 : nl_e;
            col    <= below ? col1 : col_after;
            halted <= below;
          end
        end
      end
    end
  end

  assign m_tvalid = o_valid;
  assign m_res    = o_res;

endmodule

`default_nettype wire

// ===== hdl/text_line_wrap_layout_top.sv =====
// Text line-wrap layout: a byte's first result passes the work queue, the pending
// register and the output register; it waits in the pending register while a later
// step of that byte that places nothing is to run. One byte is taken per cycle while
// the queue is not full; an entry's steps run in turn: release of a held lead, the
// byte itself, then an end report. Reset restores the register defaults, empties the
// work queue and drops any held lead; a text starts at origin.
`timescale 1ns / 1ps
`default_nettype none

module text_line_wrap_layout_top (
  input  logic                          clk,
  input  logic                          rst,
  // slave side: tdata = text_byte[7:0]; tlast = is_final
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,
  input  logic                          s_tlast,
  // master side: tdata = glyph_x[11:0], glyph_y[23:12], glyph_code[39:24],
  // next_line_y[51:40], zero fill[55:52]; tuser = kind[1:0]; tlast = run_end
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tlw_pkg::TDATA_W-1:0]   m_tdata,
  output logic [1:0]                    m_tuser,
  output logic                          m_tlast,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tlw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tlw_pkg::CFG_DAT_W-1:0] cfg_data
);

  tlw_pkg::cfg_t    cfg;
  logic             q_full;
  logic             q_empty;
  logic             push;
  logic             pop;
  tlw_pkg::entry_t  wr_entry;
  tlw_pkg::entry_t  head;
  tlw_pkg::result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x       <= 12'd0;
      cfg.origin_y       <= 12'd0;
      cfg.wrap_width     <= 12'd320;
      cfg.bottom_limit   <= 12'd240;
      cfg.line_height    <= 7'd16;
      cfg.ascii_offset_y <= 6'd0;
      cfg.lead_min       <= 8'd129;
      cfg.trail_min      <= 8'd64;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tlw_pkg::REG_ORIGIN_X:       cfg.origin_x       <= cfg_data;
        tlw_pkg::REG_ORIGIN_Y:       cfg.origin_y       <= cfg_data;
        tlw_pkg::REG_WRAP_WIDTH:     cfg.wrap_width     <= cfg_data;
        tlw_pkg::REG_BOTTOM_LIMIT:   cfg.bottom_limit   <= cfg_data;
        tlw_pkg::REG_LINE_HEIGHT:    cfg.line_height    <= cfg_data[6:0];
        tlw_pkg::REG_ASCII_OFFSET_Y: cfg.ascii_offset_y <= cfg_data[5:0];
        tlw_pkg::REG_LEAD_MIN:       cfg.lead_min       <= cfg_data[7:0];
        tlw_pkg::REG_TRAIL_MIN:      cfg.trail_min      <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  tlw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .entry    (wr_entry)
  );

  tlw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  tlw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_res    (res)
  );

  assign m_tdata = {4'b0000, res.next_line_y, res.glyph_code, res.glyph_y, res.glyph_x};
  assign m_tuser = res.kind;
  assign m_tlast = res.run_end;

endmodule

`default_nettype wire

// ===== hdl/tlw_checker.sv =====
// Port-level checks on the result stream of the text line-wrap layout block,
// bound to text_line_wrap_layout_top. Depends on tlw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlw_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [tlw_pkg::TDATA_W-1:0] m_tdata,
  input logic [1:0]                  m_tuser,
  input logic                        m_tlast
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result transfer withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("result payload changed while stalled");

  // The end report is always the last result of its byte.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == tlw_pkg::KIND_END |-> m_tlast)
    else $error("end report without run_end");

  a_end_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == tlw_pkg::KIND_END |-> m_tdata[39:0] == 40'd0)
    else $error("end report carries glyph fields");

  a_glyph_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != tlw_pkg::KIND_END |-> m_tdata[55:40] == 16'd0)
    else $error("glyph result carries next_line_y");

endmodule

bind text_line_wrap_layout_top tlw_checker u_tlw_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking bench for text_line_wrap_layout_top: directed texts, then random texts
// under three stall patterns, each result checked against a layout predictor kept here.
// Depends on tlw_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
  import tlw_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int ITEMS_PER_PHASE = 40;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata   = '0;
  logic                 s_tlast   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [TDATA_W-1:0]   m_tdata;
  logic [1:0]           m_tuser;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          error_count   = 0;
  int          stall_cycles  = 0;

  // Layout predictor: register copy, cursor and pair state.
  cfg_t        layout_cfg;
  int unsigned cur_col;
  int unsigned cur_row;
  logic        lead_held;
  logic [7:0]  lead_byte;
  logic        text_halted;
  logic        text_open;
  result_t     glyph_q[$];
  result_t     step_glyphs[$];

  text_line_wrap_layout_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned clip_coord(input int unsigned v);
    return (v > COORD_MAX) ? int'(COORD_MAX) : v;
  endfunction

  function automatic void emit(input kind_t k, input int unsigned gx, input int unsigned gy,
                               input logic [15:0] code, input int unsigned ny);
    result_t r;
    r.kind        = k;
    r.glyph_x     = gx[11:0];
    r.glyph_y     = gy[11:0];
    r.glyph_code  = code;
    r.next_line_y = ny[11:0];
    r.run_end     = 1'b0;
    step_glyphs.push_back(r);
  endfunction

  function automatic void advance_line();
    cur_col = 32'(layout_cfg.origin_x);
    cur_row = clip_coord(cur_row + layout_cfg.line_height);
  endfunction

  function automatic logic past_bottom();
    return (cur_row + int'(layout_cfg.line_height)) > int'(layout_cfg.bottom_limit);
  endfunction

  function automatic void place_glyph(input logic is_double, input logic [15:0] code);
    int unsigned w;
    int unsigned gy;
    w = is_double ? DOUBLE_GLYPH_WIDTH : SINGLE_GLYPH_WIDTH;
    // The first glyph on a line never wraps, however wide it is.
    if (cur_col != layout_cfg.origin_x &&
        cur_col + w > int'(layout_cfg.origin_x) + int'(layout_cfg.wrap_width)) begin
      advance_line();
    end
    if (past_bottom()) begin
      text_halted = 1'b1;
      return;
    end
    gy = is_double ? cur_row : clip_coord(cur_row + layout_cfg.ascii_offset_y);
    emit(is_double ? KIND_DOUBLE : KIND_SINGLE, cur_col, gy, code, 0);
    cur_col = clip_coord(cur_col + w);
  endfunction

  function automatic void place_single(input logic [7:0] b);
    logic [7:0] c;
    c = (b >= PRINT_LO && b <= PRINT_HI) ? b : CHAR_QMARK;
    place_glyph(1'b0, {8'h00, c});
  endfunction

  function automatic void take_byte(input logic [7:0] b, input logic fin);
    if (text_halted) return;
    if (b == CHAR_CR || b == CHAR_LF) begin
      advance_line();
      if (past_bottom()) text_halted = 1'b1;
      return;
    end
    if (b >= layout_cfg.lead_min && !fin) begin
      lead_held = 1'b1;
      lead_byte = b;
      return;
    end
    place_single(b);
  endfunction

  // Works out every result one accepted byte causes and queues them.
  function automatic void layout_step(input logic [7:0] b, input logic fin);
    logic [7:0]  lead;
    int unsigned ny;
    result_t     r;
    step_glyphs.delete();
    if (!text_open) begin
      text_open   = 1'b1;
      cur_col     = 32'(layout_cfg.origin_x);
      cur_row     = 32'(layout_cfg.origin_y);
      lead_held   = 1'b0;
      lead_byte   = '0;
      text_halted = 1'b0;
    end
    if (lead_held) begin
      lead      = lead_byte;
      lead_held = 1'b0;
      lead_byte = '0;
      if (b >= layout_cfg.trail_min) begin
        if (!text_halted) place_glyph(1'b1, {lead, b});
      end else begin
        if (!text_halted) place_single(lead);
        take_byte(b, fin);
      end
    end else begin
      take_byte(b, fin);
    end
    if (fin) begin
      ny = cur_row + layout_cfg.line_height;
      if (ny > layout_cfg.bottom_limit) ny = 32'(layout_cfg.bottom_limit);
      emit(KIND_END, 0, 0, 16'h0000, ny);
      text_open   = 1'b0;
      lead_held   = 1'b0;
      lead_byte   = '0;
      text_halted = 1'b0;
      cur_col     = 32'(layout_cfg.origin_x);
      cur_row     = 32'(layout_cfg.origin_y);
    end
    if (step_glyphs.size() > 0) begin
      r = step_glyphs.pop_back();
      r.run_end = 1'b1;
      step_glyphs.push_back(r);
    end
    foreach (step_glyphs[i]) glyph_q.push_back(step_glyphs[i]);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    $display("mismatch in %s at %0t ns: got %0h, expected %0h", what, $time, got, want);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (glyph_q.size() == 0) begin
        report_mismatch("result with nothing expected", m_tdata[39:24], 0);
      end else begin
        want = glyph_q.pop_front();
        if (m_tuser != want.kind) report_mismatch("kind", m_tuser, want.kind);
        if (m_tdata[11:0] != want.glyph_x) report_mismatch("glyph_x", m_tdata[11:0], want.glyph_x);
        if (m_tdata[23:12] != want.glyph_y)
          report_mismatch("glyph_y", m_tdata[23:12], want.glyph_y);
        if (m_tdata[39:24] != want.glyph_code)
          report_mismatch("glyph_code", m_tdata[39:24], want.glyph_code);
        if (m_tdata[51:40] != want.next_line_y)
          report_mismatch("next_line_y", m_tdata[51:40], want.next_line_y);
        if (m_tdata[55:52] != 4'h0) report_mismatch("tdata fill", m_tdata[55:52], 0);
        if (m_tlast != want.run_end) report_mismatch("run_end", m_tlast, want.run_end);
      end
    end
  end

  // Random backpressure on the master side.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Ends the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // All drivers start and end at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = fin;
    do @(posedge clk); while (!s_tready);
    layout_step(b, fin);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ORIGIN_X:       layout_cfg.origin_x       = val;
      REG_ORIGIN_Y:       layout_cfg.origin_y       = val;
      REG_WRAP_WIDTH:     layout_cfg.wrap_width     = val;
      REG_BOTTOM_LIMIT:   layout_cfg.bottom_limit   = val;
      REG_LINE_HEIGHT:    layout_cfg.line_height    = val[6:0];
      REG_ASCII_OFFSET_Y: layout_cfg.ascii_offset_y = val[5:0];
      REG_LEAD_MIN:       layout_cfg.lead_min       = val[7:0];
      REG_TRAIL_MIN:      layout_cfg.trail_min      = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Waits for every expected result, then lets the pipeline empty of bytes that
  // produced nothing.
  task automatic drain_results();
    while (glyph_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Narrow registers get random junk in the unused upper data bits.
  task automatic set_layout(input logic [11:0] ox, input logic [11:0] oy,
                            input logic [11:0] ww, input logic [11:0] bl,
                            input logic [6:0] lh, input logic [5:0] aoy,
                            input logic [7:0] lm, input logic [7:0] tm);
    drain_results();
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_WRAP_WIDTH, ww);
    write_reg(REG_BOTTOM_LIMIT, bl);
    write_reg(REG_LINE_HEIGHT, {5'($urandom_range(31)), lh});
    write_reg(REG_ASCII_OFFSET_Y, {6'($urandom_range(63)), aoy});
    write_reg(REG_LEAD_MIN, {4'($urandom_range(15)), lm});
    write_reg(REG_TRAIL_MIN, {4'($urandom_range(15)), tm});
  endtask

  // ---------------------------------------------------------------- tests

  // Printable range edges, replacement of other bytes, pairs, CR/LF after a lead,
  // and a lead byte that ends the text. Runs on the reset register values.
  task automatic test_char_codes();
    send_byte(PRINT_LO, 1'b0);
    send_byte(PRINT_HI, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(CHAR_CR, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    send_byte(8'h81, 1'b1);
  endtask

  // Wrapping at the right edge, a lead without trail on the final byte (three
  // results), then a text that runs past the bottom and halts.
  task automatic test_wrap_and_halt();
    set_layout(12'd4, 12'd2, 12'd24, 12'd40, 7'd16, 6'd63, 8'd129, 8'd64);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b0);
    send_byte(8'h64, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h30, 1'b1);
    send_byte(CHAR_LF, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    send_byte(8'h78, 1'b1);
  endtask

  // Coordinates near 4095 saturate; every byte a lead, CR never starting a pair, LF
  // taken as a trail; then top line height and thresholds in a zero-height window.
  task automatic test_register_extremes();
    set_layout(12'd4088, 12'd4090, 12'd4095, 12'd4095, 7'd0, 6'd63, 8'd0, 8'd0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(CHAR_CR, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    send_byte(PRINT_HI, 1'b1);
    set_layout(12'd0, 12'd0, 12'd0, 12'd0, 7'd127, 6'd0, 8'd255, 8'd255);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h5A, 1'b1);
  endtask

  task automatic load_random_config();
    logic [11:0] ox, oy, ww, bl;
    logic [6:0]  lh;
    logic [7:0]  lm, tm;
    case ($urandom_range(7))
      0:       ox = 12'd0;
      1:       ox = 12'd4095;
      default: ox = 12'($urandom_range(300));
    endcase
    oy = ($urandom_range(7) == 0) ? 12'd4095 : 12'($urandom_range(200));
    case ($urandom_range(7))
      0:       ww = 12'($urandom_range(1));
      1:       ww = 12'd4095;
      default: ww = 12'($urandom_range(160, 8));
    endcase
    bl = ($urandom_range(7) == 0) ? 12'd4095 : 12'($urandom_range(400));
    lh = ($urandom_range(7) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(64, 1));
    case ($urandom_range(7))
      0:       lm = 8'd0;
      1:       lm = 8'd255;
      default: lm = 8'($urandom_range(240, 128));
    endcase
    tm = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(128, 32));
    set_layout(ox, oy, ww, bl, lh, 6'($urandom_range(63)), lm, tm);
  endtask

  // Random texts, mostly printable text and proper pairs, with stray leads, line
  // breaks and arbitrary bytes mixed in. Once per call the sender holds off until
  // all results are back.
  task automatic test_random_texts(input int unsigned src_idle, input int unsigned dst_idle);
    int unsigned sent;
    int unsigned len;
    logic [7:0]  b;
    logic        paused;
    sent   = 0;
    paused = 1'b0;
    send_idle_pct = src_idle;
    recv_idle_pct = dst_idle;
    while (sent < ITEMS_PER_PHASE) begin
      if (sent == 0 || $urandom_range(3) == 0) load_random_config();
      len = $urandom_range(14, 1);
      // The last text of a phase is cut short so that it still ends on its final byte.
      if (len > ITEMS_PER_PHASE - sent) len = ITEMS_PER_PHASE - sent;
      for (int unsigned i = 0; i < len; i++) begin
        if (!paused && sent >= ITEMS_PER_PHASE / 2) begin
          drain_results();
          paused = 1'b1;
        end
        if (lead_held && $urandom_range(3) != 0) begin
          b = 8'($urandom_range(255, layout_cfg.trail_min));
        end else begin
          case ($urandom_range(9))
            0, 1, 2, 3: b = 8'($urandom_range(PRINT_HI, PRINT_LO));
            4, 5:       b = 8'($urandom_range(255, layout_cfg.lead_min));
            6:          b = $urandom_range(1) ? CHAR_CR : CHAR_LF;
            default:    b = 8'($urandom_range(255));
          endcase
        end
        send_byte(b, i == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    layout_cfg.origin_x       = 12'd0;
    layout_cfg.origin_y       = 12'd0;
    layout_cfg.wrap_width     = 12'd320;
    layout_cfg.bottom_limit   = 12'd240;
    layout_cfg.line_height    = 7'd16;
    layout_cfg.ascii_offset_y = 6'd0;
    layout_cfg.lead_min       = 8'd129;
    layout_cfg.trail_min      = 8'd64;
    cur_col     = 0;
    cur_row     = 0;
    lead_held   = 1'b0;
    lead_byte   = '0;
    text_halted = 1'b0;
    text_open   = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 38;
    recv_idle_pct = 72;
    test_char_codes();
    test_wrap_and_halt();
    test_register_extremes();
    test_random_texts(38, 72);
    test_random_texts(72, 38);
    test_random_texts(0, 0);

    drain_results();
    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tlw_pkg.sv
hdl/tlw_front.sv
hdl/tlw_queue.sv
hdl/tlw_back.sv
hdl/text_line_wrap_layout_top.sv
hdl/tlw_checker.sv
tb/sv/tb.sv
